@@ sv/acfs_pkg.sv @@
`default_nettype none

package acfs_pkg;

   // Width of the stream position counter unless the top level overrides it.
   localparam int unsigned POSITION_BITS_DEFAULT = 29;

   // Number of leading bytes kept, both at the start of the file and after the tag.
   localparam int unsigned WIN           = 12;
   localparam int unsigned WIN_IDX_BITS  = $clog2(WIN);
   localparam int unsigned WIN_CNT_BITS  = $clog2(WIN + 1);

   // ID3v2 tag header: ten bytes, size in the last four, footer adds ten more.
   localparam int unsigned TAG_BITS      = 29;
   localparam int unsigned TAG_HDR_LEN   = 10;
   localparam int unsigned TAG_HDR_LAST  = TAG_HDR_LEN - 1;
   localparam logic [7:0]  TAG_FOOTER    = 8'h10;

   localparam int unsigned FORMAT_BITS   = 2;

   localparam logic [31:0] MAGIC_RIFF    = 32'h52494646;  // "RIFF"
   localparam logic [31:0] MAGIC_WAVE    = 32'h57415645;  // "WAVE"
   localparam logic [31:0] MAGIC_FLAC    = 32'h664C6143;  // "fLaC"
   localparam logic [23:0] MAGIC_ID3     = 24'h494433;    // "ID3"

   // MPEG audio frame header fields.
   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [2:0]  SYNC_TOP      = 3'b111;
   localparam logic [1:0]  LAYER_RSVD    = 2'b00;
   localparam logic [3:0]  BITRATE_BAD   = 4'hF;
   localparam logic [1:0]  SRATE_RSVD    = 2'b11;

   typedef enum logic [FORMAT_BITS-1:0] {
      FMT_UNKNOWN = 2'd0,
      FMT_WAV     = 2'd1,
      FMT_FLAC    = 2'd2,
      FMT_MP3     = 2'd3
   } fmt_type;

   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

@@ sv/acfs_if.sv @@
`default_nettype none

interface acfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last;

   modport source (output valid, output byte_value, output last, input ready);
   modport sink   (input valid, input byte_value, input last, output ready);
endinterface

interface acfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] format;

   modport source (output valid, output format, input ready);
   modport sink   (input valid, input format, output ready);
endinterface

`default_nettype wire

@@ sv/audio_container_format_sniffer.sv @@
// A byte marked last passes the input register, then the result register, which shows its format code.
// Throughput: one byte per cycle; the only stall is a last byte meeting a full result register.
// The work per byte is one input register, a window write and a few compares to the result register.
// Reset: synchronous, active high; it clears the position, the tag state and both valid flags.
// The stored byte windows are not cleared; they are only read once written in the current stream.
`default_nettype none

module audio_container_format_sniffer
   import acfs_pkg::*;
#(
   parameter int unsigned POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   acfs_req_if.sink    req_ch,
   acfs_rsp_if.source  rsp_ch
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Input register. It holds one byte; it moves on unless it is a last byte
   // and the result register is still full and not being taken.
   logic                    in_valid_ff, in_valid_in;
   byte_type                in_byte_ff;
   logic                    in_last_ff;

   // Stream state.
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [TAG_BITS-1:0]      tag_length_ff;
   logic                     tag_valid_ff, tag_valid_in;
   logic [WIN_CNT_BITS-1:0]  at_cnt_ff, at_cnt_in;
   byte_type                 head_ff [WIN];
   byte_type                 after_ff [WIN];

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   fmt_type                 rsp_format_ff;

   logic                    fire;
   logic                    accept;

   assign fire   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;

   assign req_ch.ready  = !in_valid_ff || fire;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.format = rsp_format_ff;

   // Window views that already include the byte in the input register, so
   // the decision for a last byte sees that byte too.
   logic                    pos_in_win;
   logic [WIN_IDX_BITS-1:0] pos_idx;
   byte_type                head_next [WIN];
   logic                    at_wr;
   logic [WIN_IDX_BITS-1:0] at_idx;
   byte_type                after_next [WIN];

   assign pos_in_win = position_ff < POSITION_BITS'(WIN);
   assign pos_idx    = position_ff[WIN_IDX_BITS-1:0];

   // The after-tag window starts filling when the position reaches the tag
   // length and keeps going on its own count until it holds WIN bytes.
   assign at_wr  = tag_valid_ff &&
                   ((at_cnt_ff != '0) ? (at_cnt_ff < WIN_CNT_BITS'(WIN))
                                      : (position_ff == POSITION_BITS'(tag_length_ff)));
   assign at_idx = at_cnt_ff[WIN_IDX_BITS-1:0];

   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         head_next[i]  = (pos_in_win && pos_idx == WIN_IDX_BITS'(i)) ? in_byte_ff
                                                                      : head_ff[i];
         after_next[i] = (at_wr && at_idx == WIN_IDX_BITS'(i)) ? in_byte_ff : after_ff[i];
      end
   end

   // Tag header check, done when the tenth byte is in the input register.
   logic                judge_now;
   logic                judge_ok;
   logic [27:0]         tag_size;
   logic [TAG_BITS-1:0] tag_length_calc;

   assign judge_now = position_ff == POSITION_BITS'(TAG_HDR_LAST);
   assign tag_size  = {head_next[6][6:0], head_next[7][6:0],
                       head_next[8][6:0], head_next[9][6:0]};
   assign judge_ok  = ({head_next[0], head_next[1], head_next[2]} == MAGIC_ID3) &&
                      (head_next[3] != SYNC_BYTE) && (head_next[4] != SYNC_BYTE) &&
                      !head_next[6][7] && !head_next[7][7] &&
                      !head_next[8][7] && !head_next[9][7];
   assign tag_length_calc = TAG_BITS'(TAG_HDR_LEN) + TAG_BITS'(tag_size) +
                            (((head_next[5] & TAG_FOOTER) != '0) ? TAG_BITS'(TAG_HDR_LEN)
                                                                 : '0);

   logic                    tag_valid_now;
   logic [WIN_CNT_BITS-1:0] at_cnt_now;

   assign tag_valid_now = judge_now ? judge_ok : tag_valid_ff;
   assign at_cnt_now    = at_wr ? at_cnt_ff + 1'b1 : at_cnt_ff;

   // Format decision. The byte count of the stream is position plus one, so
   // "at least k bytes" is a compare of the position against k minus one.
   logic    have3, have4, have12;
   logic    head_riff, head_wave, head_flac, head_id3;
   logic    tag_flac, tag_riff, tag_wave;
   logic    mp3_sync;
   fmt_type format_now;

   assign have3  = position_ff >= POSITION_BITS'(2);
   assign have4  = position_ff >= POSITION_BITS'(3);
   assign have12 = position_ff >= POSITION_BITS'(WIN - 1);

   assign head_riff = have4 &&
      ({head_next[0], head_next[1], head_next[2], head_next[3]} == MAGIC_RIFF);
   assign head_wave = have12 &&
      ({head_next[8], head_next[9], head_next[10], head_next[11]} == MAGIC_WAVE);
   assign head_flac = have4 &&
      ({head_next[0], head_next[1], head_next[2], head_next[3]} == MAGIC_FLAC);
   assign head_id3  = have3 && ({head_next[0], head_next[1], head_next[2]} == MAGIC_ID3);

   assign tag_flac = tag_valid_now && (at_cnt_now >= WIN_CNT_BITS'(4)) &&
      ({after_next[0], after_next[1], after_next[2], after_next[3]} == MAGIC_FLAC);
   assign tag_riff = tag_valid_now && (at_cnt_now >= WIN_CNT_BITS'(4)) &&
      ({after_next[0], after_next[1], after_next[2], after_next[3]} == MAGIC_RIFF);
   assign tag_wave = tag_valid_now && (at_cnt_now == WIN_CNT_BITS'(WIN)) &&
      ({after_next[8], after_next[9], after_next[10], after_next[11]} == MAGIC_WAVE);

   assign mp3_sync = have4 && (head_next[0] == SYNC_BYTE) &&
                     (head_next[1][7:5] == SYNC_TOP) &&
                     (head_next[1][2:1] != LAYER_RSVD) &&
                     (head_next[2][7:4] != BITRATE_BAD) &&
                     (head_next[2][3:2] != SRATE_RSVD);

   always_comb begin
      priority if (head_riff && head_wave) begin
         format_now = FMT_WAV;
      end else if (head_flac) begin
         format_now = FMT_FLAC;
      end else if (head_id3) begin
         // Inside an ID3 file the container behind the tag wins; else it is MP3.
         priority if (tag_flac) begin
            format_now = FMT_FLAC;
         end else if (tag_riff && tag_wave) begin
            format_now = FMT_WAV;
         end else begin
            format_now = FMT_MP3;
         end
      end else if (mp3_sync) begin
         format_now = FMT_MP3;
      end else begin
         format_now = FMT_UNKNOWN;
      end
   end

   // Next values of the control registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      position_in  = position_ff;
      tag_valid_in = tag_valid_ff;
      at_cnt_in    = at_cnt_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            // End of stream: the next byte starts over at offset zero.
            position_in  = '0;
            tag_valid_in = 1'b0;
            at_cnt_in    = '0;
            rsp_valid_in = 1'b1;
         end else begin
            position_in  = (position_ff == POS_MAX) ? position_ff : position_ff + 1'b1;
            tag_valid_in = tag_valid_now;
            at_cnt_in    = at_cnt_now;
         end
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         position_ff  <= '0;
         tag_valid_ff <= 1'b0;
         at_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         position_ff  <= position_in;
         tag_valid_ff <= tag_valid_in;
         at_cnt_ff    <= at_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_ch.byte_value;
         in_last_ff <= req_ch.last;
      end
      if (fire) begin
         if (pos_in_win) begin
            head_ff[pos_idx] <= in_byte_ff;
         end
         if (at_wr) begin
            after_ff[at_idx] <= in_byte_ff;
         end
         if (judge_now && judge_ok) begin
            tag_length_ff <= tag_length_calc;
         end
         if (in_last_ff) begin
            rsp_format_ff <= format_now;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/acfs_checker.sv @@
`default_nettype none

module acfs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_format
);

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its format code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_format))
      else $error("stalled result changed");

   // Input back-pressure only comes from a result that is not being taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // A fresh result must have an accepted last byte behind it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a last byte");

endmodule

bind audio_container_format_sniffer acfs_checker u_acfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_format (rsp_ch.format)
);

`default_nettype wire

@@ dv/sniffer_format_monitor.sv @@
`default_nettype none

module sniffer_format_monitor
   import acfs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   acfs_req_if        req_ch,
   acfs_rsp_if        rsp_ch,
   output int         mismatches,
   output int         outstanding,
   output int         checked,
   output logic [3:0] codes_seen
);

   localparam int unsigned POS_BITS = POSITION_BITS_DEFAULT;
   localparam logic [POS_BITS-1:0] POS_TOP = '1;

   // Shadow copy of the sniffer state.
   logic [POS_BITS-1:0]  position;
   logic [WIN-1:0][7:0]  head_win;
   logic [WIN-1:0][7:0]  after_win;
   logic [POS_BITS-1:0]  tag_len;
   logic                 tag_ok;

   fmt_type formats_due[$];
   fmt_type predicted_fmt;
   fmt_type expected_fmt;

   function automatic logic [31:0] quad(input logic [WIN-1:0][7:0] w, input int unsigned at);
      return {w[at], w[at+1], w[at+2], w[at+3]};
   endfunction

   // Runs when the tenth byte of a stream arrives.
   function automatic void judge_tag_header();
      logic [27:0] size_bits;
      tag_ok = 1'b0;
      if ({head_win[0], head_win[1], head_win[2]} == MAGIC_ID3 &&
          head_win[3] != 8'hFF && head_win[4] != 8'hFF &&
          !head_win[6][7] && !head_win[7][7] && !head_win[8][7] && !head_win[9][7]) begin
         size_bits = {head_win[6][6:0], head_win[7][6:0], head_win[8][6:0], head_win[9][6:0]};
         tag_len   = POS_BITS'(TAG_HDR_LEN) + POS_BITS'(size_bits)
                   + (((head_win[5] & TAG_FOOTER) != 8'h00) ? POS_BITS'(TAG_HDR_LEN) : '0);
         tag_ok    = 1'b1;
      end
   endfunction

   // Each magic only counts once all of its bytes are in.
   function automatic fmt_type classify(input logic [POS_BITS:0] count);
      logic [POS_BITS:0] after_count;
      fmt_type f;
      f = FMT_UNKNOWN;
      if (count >= 12 && quad(head_win, 0) == MAGIC_RIFF && quad(head_win, 8) == MAGIC_WAVE) begin
         f = FMT_WAV;
      end else if (count >= 4 && quad(head_win, 0) == MAGIC_FLAC) begin
         f = FMT_FLAC;
      end else if (count >= 3 && {head_win[0], head_win[1], head_win[2]} == MAGIC_ID3) begin
         f = FMT_MP3;
         if (tag_ok && count > {1'b0, tag_len}) begin
            after_count = count - {1'b0, tag_len};
            if (after_count >= 4 && quad(after_win, 0) == MAGIC_FLAC) begin
               f = FMT_FLAC;
            end else if (after_count >= 12 && quad(after_win, 0) == MAGIC_RIFF &&
                         quad(after_win, 8) == MAGIC_WAVE) begin
               f = FMT_WAV;
            end
         end
      end else if (count >= 4 && head_win[0] == SYNC_BYTE && head_win[1][7:5] == SYNC_TOP &&
                   head_win[1][2:1] != LAYER_RSVD && head_win[2][7:4] != BITRATE_BAD &&
                   head_win[2][3:2] != SRATE_RSVD) begin
         f = FMT_MP3;
      end
      return f;
   endfunction

   // Advances the shadow state by one byte; returns 1 when the byte closes a stream.
   function automatic logic take_byte(input byte_type b, input logic is_last,
                                      output fmt_type fmt);
      logic [POS_BITS:0]   count;
      logic [POS_BITS-1:0] rel;
      fmt = FMT_UNKNOWN;
      if (position < WIN) head_win[position[WIN_IDX_BITS-1:0]] = b;
      if (position == TAG_HDR_LAST) judge_tag_header();
      rel = position - tag_len;
      if (tag_ok && position >= tag_len && rel < WIN) after_win[rel[WIN_IDX_BITS-1:0]] = b;
      count = {1'b0, position} + 1'b1;
      if (position != POS_TOP) position = position + 1'b1;
      if (!is_last) return 1'b0;
      fmt      = classify(count);
      position = '0;
      tag_ok   = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         position    = '0;
         head_win    = '0;
         after_win   = '0;
         tag_len     = '0;
         tag_ok      = 1'b0;
         formats_due.delete();
         mismatches  = 0;
         checked     = 0;
         codes_seen  = '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (take_byte(req_ch.byte_value, req_ch.last, predicted_fmt)) begin
               formats_due.push_back(predicted_fmt);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (formats_due.size() == 0) begin
               $display("%0t: format %0d arrived with none expected", $time, rsp_ch.format);
               mismatches++;
            end else begin
               expected_fmt = formats_due.pop_front();
               checked++;
               codes_seen[rsp_ch.format] = 1'b1;
               if (rsp_ch.format !== expected_fmt) begin
                  $display("%0t: format mismatch, expected %0d, actual %0d",
                           $time, expected_fmt, rsp_ch.format);
                  mismatches++;
               end
            end
         end
      end
      outstanding = formats_due.size();
   end

endmodule

`default_nettype wire

@@ dv/tb_audio_container_format_sniffer.sv @@
`default_nettype none

module tb_audio_container_format_sniffer;
   import acfs_pkg::*;

   // The run is bounded by this many clock cycles.
   localparam int unsigned CYCLE_LIMIT     = 200000;
   // Approximate number of random bytes, split evenly over the four idling mixes.
   localparam int unsigned RANDOM_BYTES    = 850;
   // Length of the stretch in which the result side refuses every item.
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   // A version byte of this value makes an ID3 tag header invalid.
   localparam byte_type    VERSION_BAD     = 8'hFF;

   logic clock;
   logic reset;

   acfs_req_if req_ch ();
   acfs_rsp_if rsp_ch ();

   int   mismatches;
   int   outstanding;
   int   checked;
   logic [3:0] codes_seen;

   // Percentages that the current phase gives to sender gaps and receiver stalls.
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   logic hold_off_request   = 1'b0;

   int   bytes_sent   = 0;
   int   streams_sent = 0;
   int   cycle_count  = 0;

   // Bytes of the stream being built; the final one goes out marked last.
   byte_type stream_bytes[$];

   audio_container_format_sniffer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The monitor predicts a format code for every stream and compares it with what comes out.
   sniffer_format_monitor i_format_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .codes_seen  (codes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Result side. Each falling edge picks a new ready level. When the stimulus asks for a
   // hold-off, ready stays low for a fixed stretch that this process counts down itself.
   initial begin
      int   hold_left;
      logic hold_taken;
      hold_left    = 0;
      hold_taken   = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_taken) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // Offers one byte, possibly after a random gap, and returns at the falling edge after the
   // item was taken. It must be called at a falling edge. Only one assignment to valid happens
   // per falling edge, so a valid that stays high from item to item is never toggled.
   task automatic send_byte(input byte_type b, input logic is_last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.byte_value <= b;
      req_ch.last       <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++) begin
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      end
      streams_sent++;
      stream_bytes.delete();
   endtask

   // Pushes a four-byte magic or header word, first byte from the top.
   task automatic push_word(input logic [31:0] w);
      stream_bytes.push_back(w[31:24]);
      stream_bytes.push_back(w[23:16]);
      stream_bytes.push_back(w[15:8]);
      stream_bytes.push_back(w[7:0]);
   endtask

   task automatic push_random(input int unsigned count);
      for (int unsigned k = 0; k < count; k++) begin
         stream_bytes.push_back(byte_type'($urandom_range(0, 255)));
      end
   endtask

   // Version bytes of an ID3 header: mostly legal, sometimes the value that voids the tag.
   function automatic byte_type pick_version();
      if ($urandom_range(0, 4) == 0) return VERSION_BAD;
      return byte_type'($urandom_range(0, 254));
   endfunction

   // Builds one random stream. Most are well-formed files of each kind with random content, so
   // that the deeper rules (the tag skip and the magic after it) are reached often; the rest is
   // plain noise. Some streams are cut short to hit partial magics and partial tag headers.
   task automatic build_random_stream();
      int unsigned kind;
      int unsigned tag_size;
      int unsigned keep;
      int unsigned bad_at;
      byte_type    flags;
      byte_type    second;
      logic [27:0] size_bits;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            push_word(MAGIC_RIFF);
            push_random(4);
            push_word(MAGIC_WAVE);
            push_random($urandom_range(0, 6));
         end
         2: begin
            push_word(MAGIC_FLAC);
            push_random($urandom_range(0, 4));
         end
         3, 4, 5: begin
            push_word({MAGIC_ID3, pick_version()});
            stream_bytes.push_back(pick_version());
            flags = byte_type'($urandom_range(0, 255));
            stream_bytes.push_back(flags);
            if ($urandom_range(0, 3) == 0) begin
               // Arbitrary size bytes, top bits included; the tag end usually lies past the data.
               push_random(4 + $urandom_range(0, 10));
            end else begin
               tag_size  = $urandom_range(0, 24);
               size_bits = 28'(tag_size);
               stream_bytes.push_back({1'b0, size_bits[27:21]});
               stream_bytes.push_back({1'b0, size_bits[20:14]});
               stream_bytes.push_back({1'b0, size_bits[13:7]});
               stream_bytes.push_back({1'b0, size_bits[6:0]});
               // Now and then one size byte breaks the syncsafe rule, which voids the tag.
               if ($urandom_range(0, 7) == 0) begin
                  bad_at = 6 + $urandom_range(0, 3);
                  stream_bytes[bad_at][7] = 1'b1;
               end
               push_random(tag_size + (((flags & TAG_FOOTER) != 8'h00) ? TAG_HDR_LEN : 0));
               case ($urandom_range(0, 2))
                  0: begin
                     push_word(MAGIC_FLAC);
                     push_random($urandom_range(0, 3));
                  end
                  1: begin
                     push_word(MAGIC_RIFF);
                     push_random(4);
                     push_word(MAGIC_WAVE);
                     push_random($urandom_range(0, 3));
                  end
                  default: push_random($urandom_range(0, 6));
               endcase
            end
         end
         6, 7: begin
            stream_bytes.push_back(SYNC_BYTE);
            second = byte_type'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0) second[7:5] = SYNC_TOP;
            stream_bytes.push_back(second);
            push_random(2 + $urandom_range(0, 4));
         end
         default: push_random($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 5) == 0) begin
         keep = $urandom_range(1, stream_bytes.size());
         while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
      end
   endtask

   initial begin
      int unsigned phase_target;
      req_ch.valid      = 1'b0;
      req_ch.byte_value = '0;
      req_ch.last       = 1'b0;
      reset             = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed streams, with no idling on either side.
      // A bare FLAC magic.
      push_word(MAGIC_FLAC);
      send_stream();
      // The smallest legal ID3 tag (size zero, no footer) followed by a FLAC magic.
      push_word({MAGIC_ID3, 8'h00});
      push_random(0);
      for (int k = 0; k < 6; k++) stream_bytes.push_back(8'h00);
      push_word(MAGIC_FLAC);
      send_stream();
      // A plain MPEG frame header: layer III, legal bitrate and sample rate codes.
      push_word(32'hFFFB9044);
      send_stream();
      // One-byte streams at both extremes of the byte value; neither names a format.
      stream_bytes.push_back(8'h00);
      send_stream();
      stream_bytes.push_back(8'hFF);
      send_stream();

      // Random streams in four phases: no idling, sender gaps, receiver stalls, and both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 45;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 45;
            end
            default: begin
               sender_idle_pct    = 19;
               receiver_stall_pct = 19;
            end
         endcase
         if (phase == 0) begin
            // Back-pressure burst: the result side holds off while very short streams keep
            // coming, so results pile up and the block has to refuse further input.
            hold_off_request <= 1'b1;
            for (int s = 0; s < 24; s++) begin
               push_random($urandom_range(1, 2));
               send_stream();
            end
         end
         phase_target = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < phase_target) begin
            build_random_stream();
            send_stream();
         end
      end

      // Drain: stop offering input, let the result side run free, and wait for the last codes.
      req_ch.valid      <= 1'b0;
      receiver_stall_pct = 0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Sent %0d bytes in %0d streams across four gap/stall mixes and one hold-off burst.",
               bytes_sent, streams_sent);
      $display("Compared %0d format codes; codes seen, mp3..unknown: %b.", checked, codes_seen);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/acfs_pkg.sv
sv/acfs_if.sv
sv/audio_container_format_sniffer.sv
sv/acfs_checker.sv
dv/sniffer_format_monitor.sv
dv/tb_audio_container_format_sniffer.sv
